/* rtl/pcd_pkg.sv */
// Shared types and constants for the pressure contact detector.
// Used by every module of the block; depends on nothing else.

package pcd_pkg;

	// Sensor and arithmetic constants
	localparam int ADC_BITS         = 12;
	localparam int OVERSAMPLE_SHIFT = 3;   // eight conversions are summed
	localparam int SUM_W            = 15;
	localparam int TIME_W           = 32;
	localparam int OFFS_W           = 10;
	localparam int MS_W             = 16;
	localparam int SMOOTH_W         = ADC_BITS + 8;   // Q12.8
	localparam int FORCE_W          = 10;
	localparam int DIVIDEND_W       = ADC_BITS + FORCE_W;
	localparam int DIV_STEPS        = FORCE_W;
	localparam int DIV_CNT_W        = $clog2(DIV_STEPS);
	localparam int ALU_W            = TIME_W;

	localparam logic [ADC_BITS-1:0]   ADC_MAX       = {ADC_BITS{1'b1}};
	localparam logic [7:0]            EMA_OLD       = 8'd154;
	localparam logic [7:0]            EMA_NEW       = 8'd102;
	localparam logic [ADC_BITS-1:0]   MIN_SPAN      = ADC_BITS'(150);
	localparam logic [FORCE_W-1:0]    DIGITAL_FORCE = FORCE_W'(150);
	localparam logic [FORCE_W-1:0]    FORCE_SCALE   = FORCE_W'(1000);

	// Configuration register indexes
	localparam int REG_IDX_W = 3;
	localparam int REG_W     = 16;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_ANALOG_MODE,
		REG_ACTIVE_HIGH,
		REG_START_BASELINE,
		REG_TOUCH_OFFSET,
		REG_RELEASE_OFFSET,
		REG_DEBOUNCE_MS,
		REG_IDLE_SETTLE_MS,
		REG_DRIFT_INTERVAL_MS
	} reg_idx_t;

	// Configuration as seen by the sequencer
	typedef struct packed {
		logic                analog_mode;
		logic                active_high;
		logic [ADC_BITS-1:0] start_baseline;
		logic [OFFS_W-1:0]   touch_offset;
		logic [OFFS_W-1:0]   release_offset;
		logic [MS_W-1:0]     debounce_ms;
		logic [MS_W-1:0]     idle_settle_ms;
		logic [MS_W-1:0]     drift_interval_ms;
	} cfg_t;

	// Input item, first field in the highest bits
	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              digital_level;
		logic [SUM_W-1:0]  sample_sum;
	} in_item_t;

	// Result item, first field in the highest bits
	typedef struct packed {
		logic [TIME_W-1:0]   samples_seen;
		logic [FORCE_W-1:0]  force_centi_n;
		logic [ADC_BITS-1:0] zero_baseline;
		logic [ADC_BITS-1:0] filtered_value;
		logic [ADC_BITS-1:0] raw_value;
		logic                state_changed;
		logic                contact;
	} out_item_t;

	localparam int IN_W  = $bits(in_item_t);
	localparam int OUT_W = $bits(out_item_t);

	// Shared subtract and compare unit
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] diff;   // a - b modulo 2^ALU_W
		logic             ge;     // a >= b, unsigned
	} alu_res_t;

endpackage

/* rtl/pcd_cfg.sv */
// Configuration register file of the pressure contact detector.
// Depends on pcd_pkg for the register indexes and the cfg_t struct.

module pcd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [pcd_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [pcd_pkg::REG_W-1:0]     wr_data,
	output pcd_pkg::cfg_t                 cfg,
	output logic                         tare
);
	import pcd_pkg::*;

	cfg_t cfg_q;
	logic tare_q;

	// Register writes; a write to the start baseline also asks for a tare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.analog_mode       <= 1'b1;
			cfg_q.active_high       <= 1'b1;
			cfg_q.start_baseline    <= '0;
			cfg_q.touch_offset      <= OFFS_W'(80);
			cfg_q.release_offset    <= OFFS_W'(35);
			cfg_q.debounce_ms       <= MS_W'(40);
			cfg_q.idle_settle_ms    <= MS_W'(1500);
			cfg_q.drift_interval_ms <= MS_W'(300);
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_ANALOG_MODE:       cfg_q.analog_mode       <= wr_data[0];
				REG_ACTIVE_HIGH:       cfg_q.active_high       <= wr_data[0];
				REG_START_BASELINE:    cfg_q.start_baseline    <= wr_data[ADC_BITS-1:0];
				REG_TOUCH_OFFSET:      cfg_q.touch_offset      <= wr_data[OFFS_W-1:0];
				REG_RELEASE_OFFSET:    cfg_q.release_offset    <= wr_data[OFFS_W-1:0];
				REG_DEBOUNCE_MS:       cfg_q.debounce_ms       <= wr_data[MS_W-1:0];
				REG_IDLE_SETTLE_MS:    cfg_q.idle_settle_ms    <= wr_data[MS_W-1:0];
				REG_DRIFT_INTERVAL_MS: cfg_q.drift_interval_ms <= wr_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Tare fires in the cycle after the write, when the new start baseline is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q <= 1'b0;
		end else begin
			tare_q <= wr_en && (reg_idx_t'(wr_index) == REG_START_BASELINE);
		end
	end

	assign cfg  = cfg_q;
	assign tare = tare_q;

endmodule

/* rtl/pcd_alu.sv */
// Shared 32-bit subtract and compare unit of the pressure contact detector.
// Depends on pcd_pkg for the request and result structs.

module pcd_alu (
	input  pcd_pkg::alu_req_t req,
	output pcd_pkg::alu_res_t res
);
	import pcd_pkg::*;

	logic [ALU_W:0] wide_diff;

	// One subtraction gives both the difference and the unsigned compare
	always_comb begin
		wide_diff = {1'b0, req.a} - {1'b0, req.b};
		res.diff  = wide_diff[ALU_W-1:0];
		res.ge    = !wide_diff[ALU_W];
	end

endmodule

/* rtl/pcd_seq.sv */
// Sequencer and detector state of the pressure contact detector.
// Depends on pcd_pkg; drives the shared pcd_alu through alu_req/alu_res.

module pcd_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcd_pkg::cfg_t        cfg,
	input  logic                 tare,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pcd_pkg::in_item_t    in_item,
	input  logic                 out_free,
	output logic                 res_load,
	output pcd_pkg::out_item_t   res_item,
	output pcd_pkg::alu_req_t    alu_req,
	input  pcd_pkg::alu_res_t    alu_res
);
	import pcd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMA,
		ST_BASE,
		ST_LCT,
		ST_SETTLE,
		ST_DEB,
		ST_LDT,
		ST_DRFCMP,
		ST_DRIFT,
		ST_THR,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	// Detector state kept across items
	logic [SMOOTH_W-1:0] smoothed_q;
	logic [ADC_BITS-1:0] baseline_q;
	logic                contact_q;
	logic [1:0]          cand_q;
	logic [TIME_W-1:0]   lct_q;
	logic [TIME_W-1:0]   ldt_q;
	logic [TIME_W-1:0]   count_q;

	// Per-item working registers
	logic [TIME_W-1:0]     now_q;
	logic [ADC_BITS-1:0]   raw_q;
	logic                  prop_q;
	logic [TIME_W-1:0]     diff_q;
	logic                  settle_ok_q;
	logic                  deb_ok_q;
	logic                  drift_ok_q;
	logic [DIVIDEND_W-1:0] rem_q;
	logic [FORCE_W-1:0]    quo_q;
	logic [ADC_BITS-1:0]   span_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [FORCE_W-1:0]    force_q;

	// Combinational helpers
	logic [ADC_BITS-1:0]   cur;
	logic [ADC_BITS:0]     hi_thr;
	logic [ADC_BITS:0]     lo_thr;
	logic [27:0]           ema_old_prod;
	logic [SMOOTH_W-1:0]   ema_new_prod;
	logic [ADC_BITS-1:0]   delta;
	logic [ADC_BITS-1:0]   span_raw;
	logic [1:0]            cand_inc;
	logic                  changed;
	logic [TIME_W-1:0]     count_next;

	always_comb begin
		cur          = smoothed_q[SMOOTH_W-1:8];
		hi_thr       = {1'b0, baseline_q} + (ADC_BITS+1)'(cfg.touch_offset);
		lo_thr       = {1'b0, baseline_q} + (ADC_BITS+1)'(cfg.release_offset);
		ema_old_prod = 28'(EMA_OLD) * 28'(smoothed_q);
		ema_new_prod = SMOOTH_W'(EMA_NEW) * SMOOTH_W'(raw_q);
		delta        = (cur > baseline_q) ? (cur - baseline_q) : '0;
		span_raw     = ADC_MAX - baseline_q;
		cand_inc     = (cand_q == 2'd2) ? 2'd2 : (cand_q + 2'd1);
		changed      = (prop_q != contact_q) && deb_ok_q;
		count_next   = count_q + TIME_W'(1);
	end

	// Operand selection for the shared subtract and compare unit
	always_comb begin
		alu_req = '0;
		case (state_q)
			ST_LCT: begin
				alu_req.a = now_q;
				alu_req.b = lct_q;
			end
			ST_SETTLE: begin
				alu_req.a = ALU_W'(cfg.idle_settle_ms);
				alu_req.b = diff_q;
			end
			ST_DEB: begin
				alu_req.a = ALU_W'(cfg.debounce_ms);
				alu_req.b = diff_q;
			end
			ST_LDT: begin
				alu_req.a = now_q;
				alu_req.b = ldt_q;
			end
			ST_DRFCMP: begin
				alu_req.a = ALU_W'(cfg.drift_interval_ms);
				alu_req.b = diff_q;
			end
			ST_DIV: begin
				alu_req.a = ALU_W'(rem_q);
				alu_req.b = ALU_W'(span_q) << div_cnt_q;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);
	assign res_load = (state_q == ST_DONE) && out_free;

	// Result fields, valid while res_load is high
	always_comb begin
		res_item.contact        = changed ? prop_q : contact_q;
		res_item.state_changed  = changed;
		res_item.raw_value      = raw_q;
		res_item.filtered_value = cur;
		res_item.zero_baseline  = baseline_q;
		res_item.force_centi_n  = force_q;
		res_item.samples_seen   = count_next;
	end

	// Sequencer, detector state and per-item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			smoothed_q  <= '0;
			baseline_q  <= '0;
			contact_q   <= 1'b0;
			cand_q      <= '0;
			lct_q       <= '0;
			ldt_q       <= '0;
			count_q     <= '0;
			now_q       <= '0;
			raw_q       <= '0;
			prop_q      <= 1'b0;
			diff_q      <= '0;
			settle_ok_q <= 1'b0;
			deb_ok_q    <= 1'b0;
			drift_ok_q  <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			span_q      <= '0;
			div_cnt_q   <= '0;
			force_q     <= '0;
		end else begin
			// A start baseline write retares the baseline and the smoothed value
			if (tare) begin
				baseline_q <= cfg.start_baseline;
				smoothed_q <= {cfg.start_baseline, 8'd0};
			end

			case (state_q)
				// Capture the item and set up the chosen path
				ST_IDLE: begin
					if (in_valid) begin
						now_q <= in_item.now_ms;
						if (cfg.analog_mode) begin
							raw_q   <= ADC_BITS'(in_item.sample_sum >> OVERSAMPLE_SHIFT);
							prop_q  <= contact_q;
							state_q <= ST_EMA;
						end else begin
							raw_q   <= ADC_BITS'(in_item.digital_level);
							prop_q  <= cfg.active_high ? in_item.digital_level
										  : !in_item.digital_level;
							force_q <= (cfg.active_high == in_item.digital_level)
										? DIGITAL_FORCE : '0;
							state_q <= ST_LCT;
						end
					end
				end

				// Smoothing: 154/256 of the old value plus 102/256 of the new one
				ST_EMA: begin
					smoothed_q <= ema_old_prod[27:8] + ema_new_prod;
					state_q    <= ST_BASE;
				end

				// The baseline follows any lower reading at once
				ST_BASE: begin
					if (cur < baseline_q)
						baseline_q <= cur;
					state_q <= ST_LCT;
				end

				// Time since the last accepted state change
				ST_LCT: begin
					diff_q  <= alu_res.diff;
					state_q <= cfg.analog_mode ? ST_SETTLE : ST_DEB;
				end

				ST_SETTLE: begin
					settle_ok_q <= !alu_res.ge;
					state_q     <= ST_DEB;
				end

				ST_DEB: begin
					deb_ok_q <= !alu_res.ge;
					state_q  <= cfg.analog_mode ? ST_LDT : ST_DONE;
				end

				// Time since the last drift step
				ST_LDT: begin
					diff_q  <= alu_res.diff;
					state_q <= ST_DRFCMP;
				end

				ST_DRFCMP: begin
					drift_ok_q <= !alu_res.ge;
					state_q    <= ST_DRIFT;
				end

				// One-count drift toward the reading while idle
				ST_DRIFT: begin
					if (!contact_q && settle_ok_q && drift_ok_q
						&& ({1'b0, cur} < lo_thr)) begin
						ldt_q <= now_q;
						if (cur > baseline_q)
							baseline_q <= baseline_q + ADC_BITS'(1);
						else if (cur < baseline_q)
							baseline_q <= baseline_q - ADC_BITS'(1);
					end
					state_q <= ST_THR;
				end

				// Hysteresis and the set-up of the force division
				ST_THR: begin
					logic prop_n;
					prop_n = contact_q;
					if (!contact_q) begin
						if ({1'b0, cur} >= hi_thr) begin
							cand_q <= cand_inc;
							prop_n = (cand_inc == 2'd2);
						end else begin
							cand_q <= '0;
						end
					end else if ({1'b0, cur} <= lo_thr) begin
						prop_n = 1'b0;
						cand_q <= '0;
					end
					prop_q    <= prop_n;
					rem_q     <= DIVIDEND_W'(delta) * DIVIDEND_W'(FORCE_SCALE);
					span_q    <= (span_raw < MIN_SPAN) ? MIN_SPAN : span_raw;
					quo_q     <= '0;
					div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
					force_q   <= '0;
					state_q   <= prop_n ? ST_DIV : ST_DONE;
				end

				// Restoring division, one quotient bit a cycle
				ST_DIV: begin
					if (alu_res.ge)
						rem_q <= alu_res.diff[DIVIDEND_W-1:0];
					quo_q <= {quo_q[FORCE_W-2:0], alu_res.ge};
					if (div_cnt_q == '0) begin
						force_q <= {quo_q[FORCE_W-2:0], alu_res.ge};
						state_q <= ST_DONE;
					end else begin
						div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					end
				end

				// Debounce, counter and hand-off to the output register
				ST_DONE: begin
					if (out_free) begin
						count_q <= count_next;
						if (changed) begin
							contact_q <= prop_q;
							lct_q     <= now_q;
						end
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/pressure_contact_detector.sv */
// Top level of the pressure contact detector: ports, output register and
// instances. Depends on pcd_pkg, pcd_cfg, pcd_alu and pcd_seq.
//
//   Channel  Signals                          Direction  Payload
//   s        s_tvalid s_tready s_tdata[47:0]  in         one sensor sample
//   m        m_tvalid m_tready m_tdata[79:0]  out        one detector result
//   config   wr_en wr_index[2:0] wr_data[15:0] in        register write
//
// An analog item passes through the smoothing, baseline, timing, drift and
// threshold steps; when contact is proposed the force division follows, one
// quotient bit a cycle on the shared 32-bit subtract unit. A digital item
// takes only the timing and debounce steps. The result is loaded into an output
// register; a stalled result holds the sequencer in its last step until the register frees up.
// Reset loads the register defaults and the start state; there is no clearing pass.

module pressure_contact_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample_sum[14:0], digital_level[15], now_ms[47:16]
	input  logic [pcd_pkg::IN_W-1:0]          s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// contact[0], state_changed[1], raw_value[13:2], filtered_value[25:14],
	// zero_baseline[37:26], force_centi_n[47:38], samples_seen[79:48]
	output logic [pcd_pkg::OUT_W-1:0]         m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              wr_en,
	input  logic [pcd_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [pcd_pkg::REG_W-1:0]         wr_data
);
	import pcd_pkg::*;

	cfg_t      cfg;
	logic      tare;
	alu_req_t  alu_req;
	alu_res_t  alu_res;
	logic      out_free;
	logic      res_load;
	out_item_t res_item;
	logic      m_valid_q;
	out_item_t m_data_q;

	pcd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg),
		.tare     (tare)
	);

	pcd_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	pcd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.tare     (tare),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item_t'(s_tdata)),
		.out_free (out_free),
		.res_load (res_load),
		.res_item (res_item),
		.alu_req  (alu_req),
		.alu_res  (alu_res)
	);

	assign out_free = !m_valid_q || m_tready;

	// Output register: holds a result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			m_data_q <= res_item;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
